// ----- sv/obs_pkg.sv -----
// Package: shared constants and types for the ordered bitset successor unit.
`timescale 1ns / 1ps
package obs_pkg;
    localparam int KEY_W     = 16;
    localparam int WORD_W    = 64;
    localparam int BIT_IDX_W = 6;
    localparam int WORD_IDX_W = 10;   // leaf word index
    localparam int GRP_IDX_W = 4;     // group index
    localparam int N_GROUPS  = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_SUCC   = 2'd3;

    typedef struct packed {
        logic                 found;
        logic [KEY_W-1:0]     succ;
        logic [KEY_W-1:0]     min_v;
        logic [KEY_W-1:0]     max_v;
        logic                 empty;
    } t_result;

    // lowest set bit of a 64-bit word (0 if none)
    function automatic logic [BIT_IDX_W-1:0] low_bit(input logic [WORD_W-1:0] v);
        logic [BIT_IDX_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) r = BIT_IDX_W'(i);
        end
        return r;
    endfunction

    // highest set bit of a 64-bit word (0 if none)
    function automatic logic [BIT_IDX_W-1:0] high_bit(input logic [WORD_W-1:0] v);
        logic [BIT_IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) r = BIT_IDX_W'(i);
        end
        return r;
    endfunction

    function automatic logic [GRP_IDX_W-1:0] low_bit16(input logic [N_GROUPS-1:0] v);
        logic [GRP_IDX_W-1:0] r;
        r = '0;
        for (int i = N_GROUPS - 1; i >= 0; i--) begin
            if (v[i]) r = GRP_IDX_W'(i);
        end
        return r;
    endfunction

    function automatic logic [GRP_IDX_W-1:0] high_bit16(input logic [N_GROUPS-1:0] v);
        logic [GRP_IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < N_GROUPS; i++) begin
            if (v[i]) r = GRP_IDX_W'(i);
        end
        return r;
    endfunction
endpackage

// ----- sv/ordered_bitset_successor_unit.sv -----
// Top level: hierarchical-bitmap ordered set with insert, delete, query and successor.
//
//  channel | dir | tdata fields (low bit first)                     | tuser
//  s_axis  | in  | operation[1:0], key[17:2], zero pad to 24          | -
//  m_axis  | out | found[0], successor_value[16:1], min_value[32:17], | -
//          |     | max_value[48:33], set_empty[49], zero pad to 56    |
//
// Each accepted beat passes through the key's leaf-word read, the change, one
// leaf read each for the new minimum and maximum, and the handover into the
// output register before the next beat is taken. A successor that leaves the
// key's own leaf word adds one more leaf read. All reads share the one leaf port.
// After reset a clearing pass sweeps all 1024 leaf words; no beat is accepted
// meanwhile. The result waits in an output register while the next beat is
// worked on; a finished result stalls only while the previous one waits.
`timescale 1ns / 1ps
module ordered_bitset_successor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // operation, key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // found, successor, min, max, empty
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LRD   = 4'd2;  // leaf/group data of key arrive
    localparam logic [3:0] S_MOD   = 4'd3;  // apply change
    localparam logic [3:0] S_SUCW  = 4'd4;  // wait leaf read of successor word
    localparam logic [3:0] S_SUCD  = 4'd5;
    localparam logic [3:0] S_MINR  = 4'd6;
    localparam logic [3:0] S_MIND  = 4'd7;
    localparam logic [3:0] S_MAXR  = 4'd8;
    localparam logic [3:0] S_MAXD  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // leaf memory (single port, registered read)
    logic [obs_pkg::WORD_W-1:0] r_leaf_mem [0:1023];
    logic [obs_pkg::WORD_W-1:0] r_leaf_q;
    logic                       leaf_we;
    logic [obs_pkg::WORD_IDX_W-1:0] leaf_addr;
    logic [obs_pkg::WORD_W-1:0] leaf_wd;

    // group summaries: 16 words in registers, top summary in flops
    logic [obs_pkg::WORD_W-1:0] r_grp [0:obs_pkg::N_GROUPS-1];
    logic [obs_pkg::N_GROUPS-1:0] r_top;

    logic [3:0]  r_state, n_state;
    logic [obs_pkg::WORD_IDX_W:0] r_clr;
    logic [1:0]  r_op;
    logic [obs_pkg::KEY_W-1:0] r_key;
    logic [obs_pkg::WORD_IDX_W-1:0] r_word;
    obs_pkg::t_result r_res;
    obs_pkg::t_result r_out;
    logic        r_ovalid;

    logic [obs_pkg::WORD_IDX_W-1:0] key_w;
    logic [obs_pkg::GRP_IDX_W-1:0]  key_g;
    logic [obs_pkg::BIT_IDX_W-1:0]  key_b;
    logic [obs_pkg::WORD_W-1:0]     key_bit, new_leaf, gmask, gword, succ_gm;
    logic [obs_pkg::N_GROUPS-1:0]   tmask;
    logic [obs_pkg::GRP_IDX_W-1:0]  sg;
    logic [obs_pkg::WORD_W-1:0]     lm;
    logic [obs_pkg::WORD_IDX_W-1:0] min_word;
    logic                           out_free;

    assign key_w   = r_key[15:6];
    assign key_g   = r_key[15:12];
    assign key_b   = r_key[5:0];
    assign key_bit = obs_pkg::WORD_W'(1) << key_b;
    assign new_leaf = (r_op == obs_pkg::OP_INSERT) ? (r_leaf_q | key_bit)
                                                   : (r_leaf_q & ~key_bit);
    assign gword   = r_grp[key_g];
    assign lm      = r_leaf_q & ({obs_pkg::WORD_W{1'b1}} << key_b);
    // group bits strictly above the key's word
    assign gmask   = ({obs_pkg::WORD_W{1'b1}} << key_w[5:0]) << 1;
    assign succ_gm = gword & gmask;
    assign tmask   = ({obs_pkg::N_GROUPS{1'b1}} << key_g) << 1;
    assign sg      = obs_pkg::low_bit16(r_top & tmask);
    // leaf word holding the smallest member
    assign min_word = {obs_pkg::low_bit16(r_top),
                       obs_pkg::low_bit(r_grp[obs_pkg::low_bit16(r_top)])};
    // output register can take a new result
    assign out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_out.empty, r_out.max_v, r_out.min_v,
                            r_out.succ, r_out.found};

    // leaf memory port control
    always_comb begin
        leaf_we   = 1'b0;
        leaf_wd   = new_leaf;
        leaf_addr = key_w;
        unique case (r_state)
            S_CLEAR: begin
                leaf_we   = 1'b1;
                leaf_wd   = '0;
                leaf_addr = r_clr[obs_pkg::WORD_IDX_W-1:0];
            end
            S_IDLE: leaf_addr = s_axis_tdata[17:8];
            S_LRD:  leaf_addr = key_w;
            S_MOD: begin
                leaf_we = (r_op == obs_pkg::OP_INSERT) || (r_op == obs_pkg::OP_DELETE);
            end
            S_MINR: leaf_addr = min_word;
            default: leaf_addr = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (leaf_we) r_leaf_mem[leaf_addr] <= leaf_wd;
        r_leaf_q <= r_leaf_mem[leaf_addr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == 11'd1023) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid && s_axis_tready) n_state = S_LRD;
            S_LRD:   n_state = S_MOD;
            S_MOD:   n_state = S_MINR;
            S_SUCW:  n_state = S_SUCD;
            S_SUCD:  n_state = S_MINR;
            S_MINR:  n_state = S_MIND;
            S_MIND:  n_state = S_MAXR;
            S_MAXR:  n_state = S_MAXD;
            S_MAXD:  n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_MOD && r_op == obs_pkg::OP_SUCC && lm == '0
            && (succ_gm != '0 || (r_top & tmask) != '0)) n_state = S_SUCW;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_top    <= '0;
            for (int i = 0; i < obs_pkg::N_GROUPS; i++) r_grp[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 11'd1;
            // output valid: raised on handover, dropped when taken
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_op  <= s_axis_tdata[1:0];
                    r_key <= s_axis_tdata[17:2];
                end
                S_MOD: begin
                    if (r_op == obs_pkg::OP_INSERT) begin
                        r_res.found <= 1'b0;
                        r_res.succ  <= '0;
                        r_grp[key_g][key_w[5:0]] <= 1'b1;
                        r_top[key_g] <= 1'b1;
                    end else if (r_op == obs_pkg::OP_DELETE) begin
                        r_res.found <= 1'b0;
                        r_res.succ  <= '0;
                        if (new_leaf == '0) begin
                            r_grp[key_g][key_w[5:0]] <= 1'b0;
                            if ((gword & ~(obs_pkg::WORD_W'(1) << key_w[5:0])) == '0)
                                r_top[key_g] <= 1'b0;
                        end
                    end else if (r_op == obs_pkg::OP_QUERY) begin
                        r_res.found <= |(r_leaf_q & key_bit);
                        r_res.succ  <= '0;
                    end else begin
                        if (lm != '0) begin
                            r_res.found <= 1'b1;
                            r_res.succ  <= {key_w, obs_pkg::low_bit(lm)};
                        end else begin
                            r_res.found <= 1'b0;
                            r_res.succ  <= '0;
                            if (succ_gm != '0)
                                r_word <= {key_g, obs_pkg::low_bit(succ_gm)};
                            else
                                r_word <= {sg, obs_pkg::low_bit(r_grp[sg])};
                        end
                    end
                end
                S_SUCD: begin
                    r_res.found <= 1'b1;
                    r_res.succ  <= {r_word, obs_pkg::low_bit(r_leaf_q)};
                end
                S_MINR: r_word <= min_word;
                S_MIND: begin
                    r_res.empty <= (r_top == '0);
                    r_res.min_v <= (r_top == '0) ? '0
                                 : {r_word, obs_pkg::low_bit(r_leaf_q)};
                    r_word <= {obs_pkg::high_bit16(r_top),
                               obs_pkg::high_bit(r_grp[obs_pkg::high_bit16(r_top)])};
                end
                S_MAXR: ;
                S_MAXD: r_res.max_v <= (r_top == '0) ? '0
                                     : {r_word, obs_pkg::high_bit(r_leaf_q)};
                S_OUT:  if (out_free) r_out <= r_res;
                default: ;
            endcase
        end
    end

    // a waiting result holds until taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result overwritten");
    // empty set reports zero bounds
    a_empty_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[49]) |-> (m_axis_tdata[48:17] == '0))
        else $error("empty set with nonzero bounds");
    // no beat taken during the clearing pass
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready) else $error("accept during clear");
endmodule

// ----- tb/tb_top.sv -----
// Testbench for the ordered bitset successor unit: directed and random set operations.
`timescale 1ns / 1ps
module tb_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // operation[1:0], key[17:2]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // found, successor, min, max, empty

    ordered_bitset_successor_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // shadow set: one bit per key
    bit       member_bits [65536];
    int       member_count;
    obs_pkg::t_result  pending_results [$];
    int       mismatch_count;
    int       beats_sent, beats_checked;
    int       cycle_count;
    bit       rx_hold;        // long receiver hold-off
    bit       rx_no_gaps;
    int       rx_wait;        // receiver idle cycles left before the next beat
    int       key_span;       // random key offsets within the key window, drawn from 0..key_span

    // expected result of one operation, applied to the shadow set
    function automatic obs_pkg::t_result apply_set_op(logic [1:0] op, logic [15:0] key);
        obs_pkg::t_result r;
        int k;
        r = '0;
        case (op)
            obs_pkg::OP_INSERT: if (!member_bits[key]) begin
                member_bits[key] = 1'b1; member_count++;
            end
            obs_pkg::OP_DELETE: if (member_bits[key]) begin
                member_bits[key] = 1'b0; member_count--;
            end
            obs_pkg::OP_QUERY: r.found = member_bits[key];
            obs_pkg::OP_SUCC: begin
                for (k = key; k < 65536; k++)
                    if (member_bits[k]) begin
                        r.found = 1'b1; r.succ = 16'(k); break;
                    end
            end
        endcase
        r.empty = (member_count == 0);
        if (member_count != 0) begin
            for (k = 0; k < 65536; k++)
                if (member_bits[k]) begin r.min_v = 16'(k); break; end
            for (k = 65535; k >= 0; k--)
                if (member_bits[k]) begin r.max_v = 16'(k); break; end
        end
        return r;
    endfunction

    // send one beat after a random gap; valid stays up for a back-to-back beat
    task automatic send_op(logic [1:0] op, logic [15:0] key, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, key, op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_set_op(op, key));
        beats_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: a random wait per beat, a long hold-off, or always ready
    always @(posedge i_clk) begin
        if (rx_hold) m_axis_tready <= 1'b0;
        else if (rx_no_gaps) m_axis_tready <= 1'b1;
        else if (m_axis_tvalid && m_axis_tready) begin
            rx_wait = $urandom_range(0, 17);
            m_axis_tready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= (rx_wait == 0);
        end else m_axis_tready <= 1'b1;
    end

    // result checker
    always @(posedge i_clk) begin
        obs_pkg::t_result got, exp_r;
        cycle_count++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.found = m_axis_tdata[0];
            got.succ  = m_axis_tdata[16:1];
            got.min_v = m_axis_tdata[32:17];
            got.max_v = m_axis_tdata[48:33];
            got.empty = m_axis_tdata[49];
            beats_checked++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result beat %h", m_axis_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch beat %0d: exp f=%b s=%h min=%h max=%h e=%b,",
                                  " got f=%b s=%h min=%h max=%h e=%b"},
                            beats_checked, exp_r.found, exp_r.succ, exp_r.min_v, exp_r.max_v,
                            exp_r.empty, got.found, got.succ, got.min_v, got.max_v, got.empty);
                end
            end
        end
        if (cycle_count > 2000000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // empty set, extremes, duplicate insert, delete of a non-member
    task automatic test_directed();
        send_op(obs_pkg::OP_QUERY, 16'h0000);
        send_op(obs_pkg::OP_SUCC, 16'h0000);
        send_op(obs_pkg::OP_DELETE, 16'h1234);
        send_op(obs_pkg::OP_INSERT, 16'hFFFF);
        send_op(obs_pkg::OP_SUCC, 16'h0000);
        send_op(obs_pkg::OP_SUCC, 16'hFFFF);
        send_op(obs_pkg::OP_INSERT, 16'h0000);
        send_op(obs_pkg::OP_INSERT, 16'h0000);
        send_op(obs_pkg::OP_QUERY, 16'h0000);
        send_op(obs_pkg::OP_SUCC, 16'h0001);
        send_op(obs_pkg::OP_INSERT, 16'h0040);
        send_op(obs_pkg::OP_INSERT, 16'h1000);
        send_op(obs_pkg::OP_SUCC, 16'h0041);
        send_op(obs_pkg::OP_SUCC, 16'h1001);
        send_op(obs_pkg::OP_DELETE, 16'hFFFF);
        send_op(obs_pkg::OP_SUCC, 16'h1001);
        send_op(obs_pkg::OP_DELETE, 16'h0000);
        send_op(obs_pkg::OP_DELETE, 16'h0000);
        send_op(obs_pkg::OP_QUERY, 16'hAAAA);
        send_op(obs_pkg::OP_QUERY, 16'h5555);
        send_op(obs_pkg::OP_DELETE, 16'h0040);
        send_op(obs_pkg::OP_DELETE, 16'h1000);
        send_op(obs_pkg::OP_SUCC, 16'h8000);
        wait_drained();
    endtask

    // random operations, keys clustered in a window or spread over the universe
    task automatic test_random(int n);
        logic [15:0] k, base;
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0) key_span = ($urandom_range(0, 1)) ? 255 : 65535;
            base = (key_span == 255) ? 16'($urandom_range(0, 255)) << 8 : 16'd0;
            k = base | 16'($urandom_range(0, key_span));
            if ($urandom_range(0, 9) == 0) k = 16'($urandom);
            send_op(2'($urandom_range(0, 3)), k, (i % 100) < 15);
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering beats, then an always-ready receiver takes back-to-back beats
    task automatic test_backpressure();
        rx_hold = 1;
        fork
            for (int i = 0; i < 8; i++)
                send_op(2'($urandom_range(0, 3)), 16'($urandom), 1);
            begin
                repeat (300) @(posedge i_clk);
                rx_hold = 0;
            end
        join
        wait_drained();
        rx_no_gaps = 1;
        for (int i = 0; i < 40; i++) send_op(2'($urandom_range(0, 3)), 16'($urandom), 1);
        wait_drained();
        rx_no_gaps = 0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(800);
        test_backpressure();
        test_random(750);
        repeat (50) @(posedge i_clk);
        $display("ran %0d operations (insert, delete, query, successor), %0d results checked",
                 beats_sent, beats_checked);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_results.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/obs_pkg.sv
sv/ordered_bitset_successor_unit.sv
tb/tb_top.sv
